// ----- sv/rmq_pkg.sv -----
// shared types and helpers for the rotation matrix to quaternion unit
package rmq_pkg;

	// which component comes from the square root
	typedef enum logic [1:0] {
		BR_W,
		BR_X,
		BR_Y,
		BR_Z
	} branch_t;

	typedef struct packed {
		branch_t br;
		logic    bad;
	} ctl_t;

	localparam int CTL_W = $bits(ctl_t);

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ----- sv/rmq_if.sv -----
// valid/ready channel interfaces for matrix input and quaternion output
interface rmq_in_if #(
	parameter int DATA_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] r00;
	logic signed [DATA_WIDTH-1:0] r10;
	logic signed [DATA_WIDTH-1:0] r20;
	logic signed [DATA_WIDTH-1:0] r01;
	logic signed [DATA_WIDTH-1:0] r11;
	logic signed [DATA_WIDTH-1:0] r21;
	logic signed [DATA_WIDTH-1:0] r02;
	logic signed [DATA_WIDTH-1:0] r12;
	logic signed [DATA_WIDTH-1:0] r22;

	modport source (output valid, r00, r10, r20, r01, r11, r21, r02, r12, r22, input ready);
	modport sink (input valid, r00, r10, r20, r01, r11, r21, r02, r12, r22, output ready);
endinterface

interface rmq_out_if #(
	parameter int DATA_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] quat_x;
	logic signed [DATA_WIDTH-1:0] quat_y;
	logic signed [DATA_WIDTH-1:0] quat_z;
	logic signed [DATA_WIDTH-1:0] quat_w;
	logic                         invalid;

	modport source (output valid, quat_x, quat_y, quat_z, quat_w, invalid, input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, invalid, output ready);
endinterface

// ----- sv/rmq_front.sv -----
// first stage: trace, branch choice, radicand and the three off-diagonal terms
module rmq_front import rmq_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 14,
	localparam int RBW = imax(FRAC_BITS + 1, DATA_WIDTH + 1) + 2,
	localparam int RFW = RBW - 1 + FRAC_BITS,
	localparam int MW  = DATA_WIDTH + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	rmq_in_if.sink               in_ch,
	output logic                 v_s1,
	output ctl_t                 ctl_s1,
	output logic [RFW-1:0]       rad_s1,
	output logic [2:0]           sgn_s1,
	output logic [2:0][MW-1:0]   mag_s1
);

	localparam logic signed [RBW-1:0] ONE = RBW'(1) <<< FRAC_BITS;

	logic signed [RBW-1:0] e00, e11, e22, trace, rad;
	logic signed [MW-1:0]  d [3];
	ctl_t                  ctl;
	logic [2:0]            sgn;
	logic [2:0][MW-1:0]    mag;
	logic [RBW-2:0]        rad_u;

	assign in_ch.ready = en;

	always_comb begin
		e00   = RBW'(in_ch.r00);
		e11   = RBW'(in_ch.r11);
		e22   = RBW'(in_ch.r22);
		trace = e00 + e11 + e22;
		if (trace > 0) begin
			ctl.br = BR_W;
			rad    = ONE + trace;
		end else if (e00 >= e11 && e00 >= e22) begin
			ctl.br = BR_X;
			rad    = ONE + e00 - e11 - e22;
		end else if (e11 > e22) begin
			ctl.br = BR_Y;
			rad    = ONE + e11 - e00 - e22;
		end else begin
			ctl.br = BR_Z;
			rad    = ONE + e22 - e00 - e11;
		end
		ctl.bad = (rad <= 0);
		rad_u   = ctl.bad ? '0 : rad[RBW-2:0];

		// lanes hold the three components not taken from the root, in x,y,z,w order
		unique case (ctl.br)
			BR_W: begin
				d[0] = MW'(in_ch.r12) - MW'(in_ch.r21);
				d[1] = MW'(in_ch.r20) - MW'(in_ch.r02);
				d[2] = MW'(in_ch.r01) - MW'(in_ch.r10);
			end
			BR_X: begin
				d[0] = MW'(in_ch.r01) + MW'(in_ch.r10);
				d[1] = MW'(in_ch.r02) + MW'(in_ch.r20);
				d[2] = MW'(in_ch.r12) - MW'(in_ch.r21);
			end
			BR_Y: begin
				d[0] = MW'(in_ch.r10) + MW'(in_ch.r01);
				d[1] = MW'(in_ch.r21) + MW'(in_ch.r12);
				d[2] = MW'(in_ch.r20) - MW'(in_ch.r02);
			end
			default: begin
				d[0] = MW'(in_ch.r20) + MW'(in_ch.r02);
				d[1] = MW'(in_ch.r21) + MW'(in_ch.r12);
				d[2] = MW'(in_ch.r01) - MW'(in_ch.r10);
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			sgn[i] = d[i][MW-1];
			mag[i] = sgn[i] ? MW'(-d[i]) : MW'(d[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl;
			rad_s1 <= {rad_u, {FRAC_BITS{1'b0}}};
			sgn_s1 <= sgn;
			mag_s1 <= mag;
		end
	end

endmodule

// ----- sv/rmq_sqrt.sv -----
// pipelined integer square root, one root bit per stage, side data carried along
module rmq_sqrt import rmq_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 14,
	parameter int SIDE_W     = 8,
	localparam int RBW = imax(FRAC_BITS + 1, DATA_WIDTH + 1) + 2,
	localparam int RFW = RBW - 1 + FRAC_BITS,
	localparam int SW  = (RFW + 1) / 2,
	localparam int NW  = 2 * SW
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              v_in,
	input  logic [RFW-1:0]    rad_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              v_out,
	output logic [SW-1:0]     root_out,
	output logic [SIDE_W-1:0] side_out
);

	logic [NW-1:0]     n_s    [SW+1];
	logic [NW-1:0]     r_s    [SW+1];
	logic [SIDE_W-1:0] side_s [SW+1];
	logic              v_s    [SW+1];

	assign n_s[0]    = NW'(rad_in);
	assign r_s[0]    = '0;
	assign side_s[0] = side_in;
	assign v_s[0]    = v_in;

	for (genvar k = 0; k < SW; k++) begin : g_step
		localparam logic [NW:0] BIT = (NW + 1)'(1) << (2 * (SW - 1 - k));
		logic [NW:0] sum;
		logic        take;

		assign sum  = {1'b0, r_s[k]} + BIT;
		assign take = ({1'b0, n_s[k]} >= sum);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k+1]    <= take ? NW'({1'b0, n_s[k]} - sum) : n_s[k];
				r_s[k+1]    <= take ? NW'(({1'b0, r_s[k]} >> 1) + BIT) : (r_s[k] >> 1);
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign v_out    = v_s[SW];
	assign root_out = r_s[SW][SW-1:0];
	assign side_out = side_s[SW];

endmodule

// ----- sv/rmq_div.sv -----
// three-lane pipelined restoring divider, rounding, saturation and output register
module rmq_div import rmq_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 14,
	localparam int RBW  = imax(FRAC_BITS + 1, DATA_WIDTH + 1) + 2,
	localparam int RFW  = RBW - 1 + FRAC_BITS,
	localparam int SW   = (RFW + 1) / 2,
	localparam int MW   = DATA_WIDTH + 1,
	localparam int NUMW = MW + FRAC_BITS + 1,
	localparam int DW   = imax(NUMW, SW + 1 + DATA_WIDTH) + 1,
	localparam int CW   = imax(SW, DATA_WIDTH) + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               v_in,
	input  logic [SW-1:0]      root,
	input  ctl_t               ctl_in,
	input  logic [2:0]         sgn_in,
	input  logic [2:0][MW-1:0] mag_in,
	rmq_out_if.source          out_ch
);

	localparam int W = DATA_WIDTH;
	localparam logic signed [W-1:0] HI = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] LO = {1'b1, {(W-1){1'b0}}};

	logic [2:0][DW-1:0] rem_s [W+1];
	logic [2:0][W-1:0]  q_s   [W+1];
	logic [2:0]         sat_s [W+1];
	logic [2:0]         sgn_s [W+1];
	logic [SW:0]        den_s [W+1];
	logic [SW-1:0]      h_s   [W+1];
	ctl_t               ctl_s [W+1];
	logic               v_s   [W+1];

	// numerator is |d| * ONE + s, divisor 2s; quotient at or above 2^W saturates
	logic [2:0][DW-1:0] num;
	logic [2:0]         sat;
	logic [SW:0]        den;
	logic [SW:0]        root_inc;

	always_comb begin
		den      = {root, 1'b0};
		root_inc = {1'b0, root} + (SW + 1)'(1);
		for (int i = 0; i < 3; i++) begin
			num[i] = DW'({mag_in[i], {FRAC_BITS{1'b0}}}) + DW'(root);
			sat[i] = (num[i] >= (DW'(den) << W));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			q_s[0]   <= '0;
			sat_s[0] <= sat;
			sgn_s[0] <= sgn_in;
			den_s[0] <= den;
			h_s[0]   <= root_inc[SW:1];
			ctl_s[0] <= ctl_in;
		end
	end

	for (genvar j = 0; j < W; j++) begin : g_bit
		logic [DW-1:0]      trial;
		logic [2:0]         take;
		logic [2:0][DW-1:0] rem_nx;
		logic [2:0][W-1:0]  q_nx;

		always_comb begin
			trial = DW'(den_s[j]) << (W - 1 - j);
			for (int i = 0; i < 3; i++) begin
				take[i]   = (rem_s[j][i] >= trial);
				rem_nx[i] = take[i] ? (rem_s[j][i] - trial) : rem_s[j][i];
				q_nx[i]   = {q_s[j][i][W-2:0], take[i]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= rem_nx;
				q_s[j+1]   <= q_nx;
				sat_s[j+1] <= sat_s[j];
				sgn_s[j+1] <= sgn_s[j];
				den_s[j+1] <= den_s[j];
				h_s[j+1]   <= h_s[j];
				ctl_s[j+1] <= ctl_s[j];
			end
		end
	end

	logic signed [W-1:0] lane [3];
	logic signed [W-1:0] hv;
	logic signed [W-1:0] qx, qy, qz, qw;
	logic [W-1:0]        qf;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qf = q_s[W][i];
			if (sat_s[W][i]) begin
				lane[i] = sgn_s[W][i] ? LO : HI;
			end else if (!sgn_s[W][i]) begin
				lane[i] = qf[W-1] ? HI : qf;
			end else begin
				lane[i] = (qf[W-1] && (|qf[W-2:0])) ? LO : W'(-qf);
			end
		end
		hv = (CW'(h_s[W]) > CW'(HI)) ? HI : W'(h_s[W]);

		unique case (ctl_s[W].br)
			BR_W: begin
				qx = lane[0]; qy = lane[1]; qz = lane[2]; qw = hv;
			end
			BR_X: begin
				qx = hv; qy = lane[0]; qz = lane[1]; qw = lane[2];
			end
			BR_Y: begin
				qx = lane[0]; qy = hv; qz = lane[1]; qw = lane[2];
			end
			default: begin
				qx = lane[0]; qy = lane[1]; qz = hv; qw = lane[2];
			end
		endcase
		if (ctl_s[W].bad) begin
			qx = '0; qy = '0; qz = '0; qw = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (en) begin
			out_ch.valid <= v_s[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.quat_x  <= qx;
			out_ch.quat_y  <= qy;
			out_ch.quat_z  <= qz;
			out_ch.quat_w  <= qw;
			out_ch.invalid <= ctl_s[W].bad;
		end
	end

endmodule

// ----- sv/rotation_matrix_to_quaternion_unit.sv -----
// top level: rotation matrix to quaternion conversion pipeline
//
//   channel   role    payload
//   in_ch     sink    r00 r10 r20 r01 r11 r21 r02 r12 r22, signed fixed point
//   out_ch    source  quat_x quat_y quat_z quat_w (saturated), invalid
//
// one transfer per cycle in and out unless out_ch stalls; the pipeline has
// one stage per root bit, SW being the root width (16 at the default widths),
// and one per quotient bit of the three-lane divider
// the whole pipeline advances together; it holds while a result waits on out_ch
// reset clears the valid bits only
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 14
) (
	input  logic       clk,
	input  logic       arst_n,
	rmq_in_if.sink     in_ch,
	rmq_out_if.source  out_ch
);

	localparam int RBW    = imax(FRAC_BITS + 1, DATA_WIDTH + 1) + 2;
	localparam int RFW    = RBW - 1 + FRAC_BITS;
	localparam int SW     = (RFW + 1) / 2;
	localparam int MW     = DATA_WIDTH + 1;
	localparam int SIDE_W = CTL_W + 3 + 3 * MW;

	logic               en;
	logic               v_s1;
	ctl_t               ctl_s1;
	logic [RFW-1:0]     rad_s1;
	logic [2:0]         sgn_s1;
	logic [2:0][MW-1:0] mag_s1;

	logic               v_rt;
	logic [SW-1:0]      root;
	logic [SIDE_W-1:0]  side_rt;
	ctl_t               ctl_rt;
	logic [2:0]         sgn_rt;
	logic [2:0][MW-1:0] mag_rt;

	assign en = !out_ch.valid || out_ch.ready;

	rmq_front #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_ch  (in_ch),
		.v_s1   (v_s1),
		.ctl_s1 (ctl_s1),
		.rad_s1 (rad_s1),
		.sgn_s1 (sgn_s1),
		.mag_s1 (mag_s1)
	);

	rmq_sqrt #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS),
		.SIDE_W     (SIDE_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s1),
		.rad_in   (rad_s1),
		.side_in  ({ctl_s1, sgn_s1, mag_s1}),
		.v_out    (v_rt),
		.root_out (root),
		.side_out (side_rt)
	);

	assign {ctl_rt, sgn_rt, mag_rt} = side_rt;

	rmq_div #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_rt),
		.root   (root),
		.ctl_in (ctl_rt),
		.sgn_in (sgn_rt),
		.mag_in (mag_rt),
		.out_ch (out_ch)
	);

	// a flagged result carries an all-zero quaternion
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.invalid |->
			out_ch.quat_x == '0 && out_ch.quat_y == '0 &&
			out_ch.quat_z == '0 && out_ch.quat_w == '0)
		else $error("invalid result with nonzero quaternion");

	// a waiting result freezes the whole pipeline, input included
	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |-> !in_ch.ready)
		else $error("input taken while output stalled");

	// a held result keeps its flag across the stall
	a_flag_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(out_ch.invalid))
		else $error("invalid flag changed during stall");

endmodule

// ----- bench/tb_rotation_matrix_to_quaternion_unit.sv -----
// testbench for the rotation matrix to quaternion unit: directed table then random matrices
module tb_rotation_matrix_to_quaternion_unit;
	import rmq_pkg::*;

	localparam int DW = 16;
	localparam int FB = 14;
	localparam longint FONE = 64'sd1 << FB;
	localparam int LATENCY = 16 + DW + 3;
	localparam int N_RANDOM = 1800;
	localparam longint CYCLE_LIMIT = 400000;

	typedef logic signed [DW-1:0] elem_t;

	typedef struct packed {
		elem_t r00, r10, r20, r01, r11, r21, r02, r12, r22;
	} matrix_t;

	typedef struct packed {
		elem_t qx, qy, qz, qw;
		logic  bad;
	} quat_t;

	typedef struct packed {
		matrix_t m;
		logic    known;
		quat_t   q;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;

	rmq_in_if  #(.DATA_WIDTH(DW)) in_ch ();
	rmq_out_if #(.DATA_WIDTH(DW)) out_ch ();

	rotation_matrix_to_quaternion_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	quat_t  pending_quats[$];
	int     n_errors = 0;
	int     n_results = 0;
	int     n_invalid = 0;
	int     n_sent = 0;
	int     send_idle_pct = 0;
	int     recv_idle_pct = 0;
	longint cycle_count = 0;
	int     branch_hits[4];

	function automatic longint root_floor(longint n);
		longint r;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= n)
				r = r + (64'sd1 << b);
		end
		return r;
	endfunction

	// d * ONE / (2s), halves away from zero
	function automatic longint scale_by_root(longint d, longint s);
		longint mag, q;
		mag = (d < 0) ? -d : d;
		q = ((mag << FB) + s) / (2 * s);
		return (d < 0) ? -q : q;
	endfunction

	function automatic elem_t clamp(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return elem_t'(v);
	endfunction

	function automatic quat_t convert_matrix(matrix_t m);
		longint a00, a10, a20, a01, a11, a21, a02, a12, a22, tr, rad, s, h;
		longint x, y, z, w;
		branch_t br;
		quat_t q;
		a00 = m.r00; a10 = m.r10; a20 = m.r20;
		a01 = m.r01; a11 = m.r11; a21 = m.r21;
		a02 = m.r02; a12 = m.r12; a22 = m.r22;
		x = 0; y = 0; z = 0; w = 0;
		tr = a00 + a11 + a22;
		if (tr > 0) begin
			br = BR_W; rad = tr + FONE;
		end else if (a00 >= a11 && a00 >= a22) begin
			br = BR_X; rad = FONE + a00 - a11 - a22;
		end else if (a11 > a22) begin
			br = BR_Y; rad = FONE + a11 - a00 - a22;
		end else begin
			br = BR_Z; rad = FONE + a22 - a00 - a11;
		end
		q.bad = (rad <= 0);
		if (!q.bad) begin
			s = root_floor(rad << FB);
			h = (s + 1) >> 1;
			case (br)
				BR_W: begin
					w = h;
					x = scale_by_root(a12 - a21, s);
					y = scale_by_root(a20 - a02, s);
					z = scale_by_root(a01 - a10, s);
				end
				BR_X: begin
					x = h;
					y = scale_by_root(a01 + a10, s);
					z = scale_by_root(a02 + a20, s);
					w = scale_by_root(a12 - a21, s);
				end
				BR_Y: begin
					x = scale_by_root(a10 + a01, s);
					y = h;
					z = scale_by_root(a21 + a12, s);
					w = scale_by_root(a20 - a02, s);
				end
				default: begin
					x = scale_by_root(a20 + a02, s);
					y = scale_by_root(a21 + a12, s);
					z = h;
					w = scale_by_root(a01 - a10, s);
				end
			endcase
		end
		q.qx = clamp(x); q.qy = clamp(y); q.qz = clamp(z); q.qw = clamp(w);
		return q;
	endfunction

	function automatic branch_t pick_branch(matrix_t m);
		if (longint'(m.r00) + m.r11 + m.r22 > 0)
			return BR_W;
		if (m.r00 >= m.r11 && m.r00 >= m.r22)
			return BR_X;
		if (m.r11 > m.r22)
			return BR_Y;
		return BR_Z;
	endfunction

	function automatic matrix_t diag(elem_t a, elem_t b, elem_t c);
		matrix_t m;
		m = '0;
		m.r00 = a; m.r11 = b; m.r22 = c;
		return m;
	endfunction

	function automatic matrix_t fill(elem_t v);
		return {9{v}};
	endfunction

	function automatic elem_t rand_elem();
		case ($urandom_range(0, 9))
			0: return elem_t'($urandom);
			1: return elem_t'($urandom_range(0, 1) ? 32767 : -32768);
			default: return elem_t'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	// mostly plausible rotations with noise, rest fully random
	function automatic matrix_t rand_matrix();
		matrix_t m;
		int k;
		m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
			rand_elem(), rand_elem(), rand_elem(), rand_elem()};
		if ($urandom_range(0, 3) != 0) begin
			k = $urandom_range(0, 3);
			m.r00 = elem_t'($signed($urandom_range(0, 2048)) - 1024 + (k == 1 ? 16384 : -8192));
			m.r11 = elem_t'($signed($urandom_range(0, 2048)) - 1024 + (k == 2 ? 16384 : -8192));
			m.r22 = elem_t'($signed($urandom_range(0, 2048)) - 1024 + (k == 3 ? 16384 : -8192));
			if (k == 0) begin
				m.r00 = elem_t'($urandom_range(0, 16384));
				m.r11 = elem_t'($urandom_range(0, 16384));
			end
		end
		return m;
	endfunction

	// sender; the valid stays high across back-to-back transfers
	task automatic send_matrix(matrix_t m);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		{in_ch.r00, in_ch.r10, in_ch.r20, in_ch.r01, in_ch.r11, in_ch.r21,
			in_ch.r02, in_ch.r12, in_ch.r22} <= m;
		pending_quats.push_back(convert_matrix(m));
		branch_hits[pick_branch(m)]++;
		n_sent++;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pending_quats.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_quats.size());
			$display("tb_rotation_matrix_to_quaternion_unit failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			out_ch.ready <= (recv_idle_pct == 0) || ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		quat_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			n_results++;
			if (out_ch.invalid)
				n_invalid++;
			if (pending_quats.size() == 0) begin
				$error("unexpected result transfer");
				n_errors++;
			end else begin
				want = pending_quats.pop_front();
				if (out_ch.quat_x !== want.qx) begin
					$error("quat_x expected %0d actual %0d", want.qx, out_ch.quat_x);
					n_errors++;
				end
				if (out_ch.quat_y !== want.qy) begin
					$error("quat_y expected %0d actual %0d", want.qy, out_ch.quat_y);
					n_errors++;
				end
				if (out_ch.quat_z !== want.qz) begin
					$error("quat_z expected %0d actual %0d", want.qz, out_ch.quat_z);
					n_errors++;
				end
				if (out_ch.quat_w !== want.qw) begin
					$error("quat_w expected %0d actual %0d", want.qw, out_ch.quat_w);
					n_errors++;
				end
				if (out_ch.invalid !== want.bad) begin
					$error("invalid expected %0b actual %0b", want.bad, out_ch.invalid);
					n_errors++;
				end
			end
		end
	end

	row_t directed[$];

	initial begin
		matrix_t m;
		row_t r;
		in_ch.valid = 0;
		out_ch.ready = 0;
		{in_ch.r00, in_ch.r10, in_ch.r20, in_ch.r01, in_ch.r11, in_ch.r21,
			in_ch.r02, in_ch.r12, in_ch.r22} = '0;

		// identity, zero (x branch, rad = ONE), negated identity, all-min, all-max, half turns
		directed.push_back('{diag(16384, 16384, 16384), 1'b1,
			'{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0}});
		directed.push_back('{fill(0), 1'b1, '{16'sd8192, 16'sd0, 16'sd0, 16'sd0, 1'b0}});
		directed.push_back('{diag(-16384, -16384, -16384), 1'b1,
			'{16'sd11585, 16'sd0, 16'sd0, 16'sd0, 1'b0}});
		directed.push_back('{fill(16'sh8000), 1'b0, '0});
		directed.push_back('{fill(16'sh7fff), 1'b0, '0});
		directed.push_back('{diag(16384, -16384, -16384), 1'b1,
			'{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0}});
		directed.push_back('{diag(-16384, 16384, -16384), 1'b1,
			'{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b0}});
		directed.push_back('{diag(-16384, -16384, 16384), 1'b1,
			'{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b0}});
		// ties between diagonal elements
		directed.push_back('{diag(-5000, -5000, -5000), 1'b0, '0});
		directed.push_back('{diag(-9000, -5000, -5000), 1'b0, '0});
		directed.push_back('{diag(-9000, -5000, -9000), 1'b0, '0});
		// trace exactly zero goes off the trace branch
		directed.push_back('{diag(100, -50, -50), 1'b0, '0});
		m = fill(16'sh7fff); m.r00 = 16'sh8000; m.r11 = 16'sh8000;
		directed.push_back('{m, 1'b0, '0});
		m = fill(16'sh8000); m.r00 = 16'sh7fff;
		directed.push_back('{m, 1'b0, '0});
		m = diag(16384, 0, 0); m.r12 = 16'sh7fff; m.r21 = 16'sh8000;
		directed.push_back('{m, 1'b0, '0});
		m = diag(0, 0, 16384); m.r01 = -16384; m.r10 = 16384;
		directed.push_back('{m, 1'b0, '0});
		m = diag(-16384, -16384, -16384); m.r10 = 16'sh5555; m.r02 = 16'shaaaa;
		directed.push_back('{m, 1'b0, '0});
		directed.push_back('{fill(16'sh5555), 1'b0, '0});
		directed.push_back('{fill(16'shaaaa), 1'b0, '0});

		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (directed[i]) begin
			r = directed[i];
			send_matrix(r.m);
			if (r.known)
				pending_quats[pending_quats.size() - 1] = r.q;
		end
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 49 : 0;
			recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 25 : 0;
			for (int i = 0; i < N_RANDOM / 3; i++) begin
				send_matrix(rand_matrix());
				if (i == 100)
					wait_drained();
			end
		end

		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		$display("sent %0d matrices, checked %0d quaternions, %0d flagged invalid",
			n_sent, n_results, n_invalid);
		$display("branches w/x/y/z: %0d/%0d/%0d/%0d",
			branch_hits[0], branch_hits[1], branch_hits[2], branch_hits[3]);
		if (n_errors == 0 && pending_quats.size() == 0)
			$display("tb_rotation_matrix_to_quaternion_unit passed");
		else
			$display("tb_rotation_matrix_to_quaternion_unit failed");
		$finish;
	end

endmodule

// ----- rotation_matrix_to_quaternion_unit.f -----
sv/rmq_pkg.sv
sv/rmq_if.sv
sv/rmq_front.sv
sv/rmq_sqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion_unit.sv
bench/tb_rotation_matrix_to_quaternion_unit.sv
